// ===== rtl/triangle_span_rasterizer_assert.svh =====
// Assertion macros used by the checker file of the span rasterizer.
`ifndef TRIANGLE_SPAN_RASTERIZER_ASSERT_SVH
`define TRIANGLE_SPAN_RASTERIZER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define TSR_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("triangle_span_rasterizer: assertion failed");

// Checked on every clock edge, reset included.
`define TSR_ASSERT_ALWAYS(lbl, ck, prop) \
    lbl: assert property (@(posedge ck) prop) \
        else $error("triangle_span_rasterizer: assertion failed");

`endif

// ===== rtl/tsr_pkg.sv =====
`timescale 1ns / 1ps
package tsr_pkg;

    // Item kinds on the input channel.
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILL_COLOUR   = 2'd2;

    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam logic [31:0] COLOUR_RESET = 32'd0;

    // Row counter width.
    localparam int ROW_BITS = 17;

    // Job bits that do not depend on the coordinate width:
    // two row indexes, the 16 bit row, on-screen and last flags, colour.
    localparam int JOB_FIXED_BITS = 2 * ROW_BITS + 16 + 2 + 32;

    localparam logic [14:0] START_MAX = 15'h7FFF;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic busy;
        logic valid;
    } div_stat_t;

endpackage

// ===== rtl/tsr_front.sv =====
`timescale 1ns / 1ps
module tsr_front import tsr_pkg::*; #(
    parameter int CW = 16,
    localparam int JW = 6 * CW + 4 + JOB_FIXED_BITS,
    localparam int EW = (CW + 3 > ROW_BITS + 2) ? CW + 3 : ROW_BITS + 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic signed [15:0]   s_ax_coord,
    input  logic signed [15:0]   s_ay_coord,
    input  logic signed [15:0]   s_bx_coord,
    input  logic signed [15:0]   s_by_coord,
    input  logic signed [15:0]   s_cx_coord,
    input  logic signed [15:0]   s_cy_coord,
    input  logic [12:0]          screen_height,
    input  logic [31:0]          fill_colour,
    input  logic                 q_full,
    output logic                 q_push,
    output logic [JW-1:0]        q_push_data
);

    logic signed [CW-1:0] x_reg [3];
    logic signed [CW-1:0] y_reg [3];
    logic [ROW_BITS-1:0]  row_idx_reg;
    logic                 busy_reg;

    logic signed [CW-1:0] tx [3];
    logic signed [CW-1:0] ty [3];
    logic signed [CW-1:0] sx [3];
    logic signed [CW-1:0] sy [3];
    logic signed [CW-1:0] tmp_x;
    logic signed [CW-1:0] tmp_y;
    logic                 flat;

    logic signed [EW-1:0] y0_e, y1_e, y2_e, i_e, total_e, h1_e, h2_e, row_e, hgt_e;
    logic signed [EW-1:0] ib_e;
    logic signed [CW:0]   dxa, dxb;
    logic signed [CW-1:0] xb;
    logic signed [CW:0]   hb;
    logic                 run, last, lower, on_screen;
    logic                 accept;

    // Three compare-swaps on the incoming vertices.
    always_comb begin
        tmp_x = '0;
        tmp_y = '0;
        tx[0] = CW'($signed(s_ax_coord));
        ty[0] = CW'($signed(s_ay_coord));
        tx[1] = CW'($signed(s_bx_coord));
        ty[1] = CW'($signed(s_by_coord));
        tx[2] = CW'($signed(s_cx_coord));
        ty[2] = CW'($signed(s_cy_coord));
        flat = (ty[0] == ty[1]) && (ty[0] == ty[2]);
        sx = tx;
        sy = ty;
        if (sy[0] > sy[1]) begin
            tmp_x = sx[0]; tmp_y = sy[0];
            sx[0] = sx[1]; sy[0] = sy[1];
            sx[1] = tmp_x; sy[1] = tmp_y;
        end
        if (sy[0] > sy[2]) begin
            tmp_x = sx[0]; tmp_y = sy[0];
            sx[0] = sx[2]; sy[0] = sy[2];
            sx[2] = tmp_x; sy[2] = tmp_y;
        end
        if (sy[1] > sy[2]) begin
            tmp_x = sx[1]; tmp_y = sy[1];
            sx[1] = sx[2]; sy[1] = sy[2];
            sx[2] = tmp_x; sy[2] = tmp_y;
        end
    end

    // Classify the next row of the active triangle.
    always_comb begin
        y0_e    = EW'(y_reg[0]);
        y1_e    = EW'(y_reg[1]);
        y2_e    = EW'(y_reg[2]);
        i_e     = EW'({1'b0, row_idx_reg});
        hgt_e   = EW'({1'b0, screen_height});
        total_e = y2_e - y0_e;
        h1_e    = y1_e - y0_e;
        h2_e    = y2_e - y1_e;
        run     = busy_reg && (i_e < total_e);
        last    = (i_e == (total_e - EW'(1)));
        lower   = (i_e > h1_e) || (h1_e == '0);
        row_e   = y0_e + i_e;
        on_screen = !row_e[EW-1] && (row_e < hgt_e);
        dxa     = (CW+1)'(x_reg[2]) - (CW+1)'(x_reg[0]);
        if (lower) begin
            xb   = x_reg[1];
            dxb  = (CW+1)'(x_reg[2]) - (CW+1)'(x_reg[1]);
            hb   = h2_e[CW:0];
            ib_e = i_e - h1_e;
        end else begin
            xb   = x_reg[0];
            dxb  = (CW+1)'(x_reg[1]) - (CW+1)'(x_reg[0]);
            hb   = h1_e[CW:0];
            ib_e = i_e;
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (s_kind == KIND_ADVANCE) && run;
    assign q_push_data = {x_reg[0], dxa, total_e[CW:0], xb, dxb, hb,
                          row_idx_reg, ib_e[ROW_BITS-1:0], row_e[15:0],
                          on_screen, last, fill_colour};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            row_idx_reg <= '0;
            for (int k = 0; k < 3; k++) begin
                x_reg[k] <= '0;
                y_reg[k] <= '0;
            end
        end else if (accept) begin
            if (s_kind == KIND_LOAD) begin
                x_reg       <= sx;
                y_reg       <= sy;
                row_idx_reg <= '0;
                busy_reg    <= !flat;
            end else if (busy_reg) begin
                if (!run) begin
                    busy_reg <= 1'b0;
                end else if (last) begin
                    busy_reg    <= 1'b0;
                    row_idx_reg <= '0;
                end else begin
                    row_idx_reg <= row_idx_reg + ROW_BITS'(1);
                end
            end
        end
    end

endmodule

// ===== rtl/tsr_fifo.sv =====
`timescale 1ns / 1ps
module tsr_fifo import tsr_pkg::*; #(
    parameter int JW = 184
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [JW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic [JW-1:0] pop_data,
    output logic          empty
);

    // Two-entry queue between the front and the back.
    logic [JW-1:0] mem [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== rtl/tsr_div.sv =====
`timescale 1ns / 1ps
module tsr_div import tsr_pkg::*; #(
    parameter int NW = 36,
    parameter int DW = 17,
    localparam int CTW = $clog2(NW + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic signed [NW-1:0] quot,
    output div_stat_t            stat
);

    // Restoring divider on magnitudes, one quotient bit per cycle.
    logic [NW-1:0]  qs_reg;
    logic [DW-1:0]  rem_reg;
    logic [DW-1:0]  den_reg;
    logic           neg_reg;
    logic [CTW-1:0] cnt_reg;
    logic           busy_reg;
    logic           valid_reg;

    logic [NW-1:0]  num_mag;
    logic [DW:0]    trial;
    logic           fits;

    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign trial   = {rem_reg, qs_reg[NW-1]};
    assign fits    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (start) begin
            qs_reg  <= num_mag;
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NW-1];
        end else if (busy_reg) begin
            qs_reg  <= {qs_reg[NW-2:0], fits};
            rem_reg <= fits ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else if (start) begin
            busy_reg  <= 1'b1;
            valid_reg <= 1'b0;
            cnt_reg   <= CTW'(NW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CTW'(1);
            if (cnt_reg == CTW'(1)) begin
                busy_reg  <= 1'b0;
                valid_reg <= 1'b1;
            end
        end
    end

    assign quot       = neg_reg ? -$signed(qs_reg) : $signed(qs_reg);
    assign stat.busy  = busy_reg;
    assign stat.valid = valid_reg;

endmodule

// ===== rtl/tsr_back.sv =====
`timescale 1ns / 1ps
module tsr_back import tsr_pkg::*; #(
    parameter int CW = 16,
    localparam int JW  = 6 * CW + 4 + JOB_FIXED_BITS,
    localparam int NW  = (2 * CW + 3 > CW + ROW_BITS + 3) ? 2 * CW + 3 : CW + ROW_BITS + 3,
    localparam int QW  = CW + 2,
    localparam int CLW = (CW + 3 > 17) ? CW + 3 : 17
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic [JW-1:0]      q_pop_data,
    input  logic [12:0]        screen_width,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_span_row,
    output logic [14:0]        m_span_start,
    output logic [12:0]        m_pixel_count,
    output logic [31:0]        m_span_colour,
    output logic               m_final_row
);

    back_state_t state_reg, state_next;

    logic signed [CW-1:0]       x0_reg, xb_reg;
    logic signed [CW:0]         dxa_reg, dxb_reg, tot_reg, hb_reg;
    logic [ROW_BITS-1:0]        ia_reg, ib_reg;
    logic [15:0]                row_reg;
    logic                       onscr_reg, last_reg;
    logic [31:0]                col_reg;

    logic signed [2*CW:0]       pa0_reg, pb0_reg;
    logic signed [CW+ROW_BITS+1:0] pa1_reg, pb1_reg;

    logic signed [NW-1:0] num_a, num_b, quot_a, quot_b;
    div_stat_t            stat_a, stat_b;
    logic                 div_start, out_load, out_free;

    logic                 m_valid_reg;
    logic signed [15:0]   m_row_reg;
    logic [14:0]          m_start_reg;
    logic [12:0]          m_cnt_reg;
    logic [31:0]          m_col_reg;
    logic                 m_last_reg;

    logic signed [QW-1:0]  qa, qb;
    logic signed [CLW-1:0] lo, hi, wid, st, en, cnt;

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            {x0_reg, dxa_reg, tot_reg, xb_reg, dxb_reg, hb_reg,
             ia_reg, ib_reg, row_reg, onscr_reg, last_reg, col_reg} <= q_pop_data;
        end
        if (state_reg == BK_MUL) begin
            pa0_reg <= x0_reg * tot_reg;
            pa1_reg <= dxa_reg * $signed({1'b0, ia_reg});
            pb0_reg <= xb_reg * hb_reg;
            pb1_reg <= dxb_reg * $signed({1'b0, ib_reg});
        end
    end

    assign num_a = NW'(pa0_reg) + NW'(pa1_reg);
    assign num_b = NW'(pb0_reg) + NW'(pb1_reg);

    tsr_div #(.NW(NW), .DW(CW + 1)) u_div_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_a),
        .den     ($unsigned(tot_reg)),
        .quot    (quot_a),
        .stat    (stat_a)
    );

    tsr_div #(.NW(NW), .DW(CW + 1)) u_div_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_b),
        .den     ($unsigned(hb_reg)),
        .quot    (quot_b),
        .stat    (stat_b)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_MUL;
            BK_MUL:  state_next = BK_SUM;
            BK_SUM:  state_next = BK_DIV;
            BK_DIV: begin
                if (stat_a.valid && stat_b.valid && !stat_a.busy && !stat_b.busy) begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:  if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            BK_IDLE: q_pop     = !q_empty;
            BK_SUM:  div_start = 1'b1;
            BK_OUT:  out_load  = out_free;
            default: ;
        endcase
    end

    // Order the edge x values into low and high, then clip against the screen.
    always_comb begin
        qa  = QW'(quot_a);
        qb  = QW'(quot_b);
        lo  = (qa > qb) ? CLW'(qb) : CLW'(qa);
        hi  = (qa > qb) ? CLW'(qa) : CLW'(qb);
        wid = CLW'({1'b0, screen_width});
        st  = '0;
        en  = '0;
        cnt = '0;
        if (onscr_reg) begin
            st  = lo[CLW-1] ? '0 : lo;
            en  = (hi < wid) ? hi : wid;
            cnt = en - st;
            if (cnt[CLW-1]) begin
                cnt = '0;
            end
            if (st > CLW'(START_MAX)) begin
                st = CLW'(START_MAX);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_row_reg   <= $signed(row_reg);
            m_start_reg <= st[14:0];
            m_cnt_reg   <= cnt[12:0];
            m_col_reg   <= col_reg;
            m_last_reg  <= last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_span_row    = m_row_reg;
    assign m_span_start  = m_start_reg;
    assign m_pixel_count = m_cnt_reg;
    assign m_span_colour = m_col_reg;
    assign m_final_row   = m_last_reg;

endmodule

// ===== rtl/triangle_span_rasterizer.sv =====
`timescale 1ns / 1ps
// Scanline triangle filler. A transaction on the s_ channel with s_kind = 0
// loads three vertices; they are sorted by y and a triangle whose three y
// values are equal is dropped. Each later transaction with s_kind = 1 yields
// one span on the m_ channel for the next row of the active triangle, the
// bottom row excluded; m_final_row marks the last one. Advances with no
// active triangle and all loads produce no result.
// The cfg_ channel writes screen width, screen height and fill colour; it is
// always ready and must only be used while no span is outstanding.
// The divider width NW is the larger of 2*COORD_BITS+3 and COORD_BITS+20
// (36 at COORD_BITS=16). The two parallel restoring dividers compute both
// edge x values one quotient bit per cycle; the back finishes one span
// before it starts on the next, while the queue takes further row jobs.
// Loads are taken unless the queue is full. A two-entry queue sits between
// the front that classifies rows and the back that divides and clips, and
// the output register lets the back finish the next span while the
// receiver stalls.
// Synchronous active-low reset clears the active triangle, the queue and the
// output valid, and restores width 640, height 480 and colour 0.
module triangle_span_rasterizer import tsr_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [15:0] s_ax_coord,
    input  logic signed [15:0] s_ay_coord,
    input  logic signed [15:0] s_bx_coord,
    input  logic signed [15:0] s_by_coord,
    input  logic signed [15:0] s_cx_coord,
    input  logic signed [15:0] s_cy_coord,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_span_row,
    output logic [14:0]        m_span_start,
    output logic [12:0]        m_pixel_count,
    output logic [31:0]        m_span_colour,
    output logic               m_final_row,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int JW = 6 * COORD_BITS + 4 + JOB_FIXED_BITS;

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [31:0] colour_reg;

    logic          q_push, q_pop, q_full, q_empty;
    logic [JW-1:0] q_push_data, q_pop_data;

    // Configuration writes are registered; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            colour_reg <= COLOUR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_data[12:0];
                REG_SCREEN_HEIGHT: height_reg <= cfg_data[12:0];
                REG_FILL_COLOUR:   colour_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Front: takes transactions, sorts loads, turns advances into row jobs.
    tsr_front #(.CW(COORD_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_ax_coord    (s_ax_coord),
        .s_ay_coord    (s_ay_coord),
        .s_bx_coord    (s_bx_coord),
        .s_by_coord    (s_by_coord),
        .s_cx_coord    (s_cx_coord),
        .s_cy_coord    (s_cy_coord),
        .screen_height (height_reg),
        .fill_colour   (colour_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_data   (q_push_data)
    );

    tsr_fifo #(.JW(JW)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Back: edge interpolation by division, clipping and the output register.
    tsr_back #(.CW(COORD_BITS)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_pop_data    (q_pop_data),
        .screen_width  (width_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_span_row    (m_span_row),
        .m_span_start  (m_span_start),
        .m_pixel_count (m_pixel_count),
        .m_span_colour (m_span_colour),
        .m_final_row   (m_final_row)
    );

endmodule

// ===== rtl/tsr_chk.sv =====
`timescale 1ns / 1ps
`include "triangle_span_rasterizer_assert.svh"
module tsr_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_span_row,
    input logic [14:0]        m_span_start,
    input logic [12:0]        m_pixel_count,
    input logic [31:0]        m_span_colour
);

    // A stalled span keeps its payload.
    `TSR_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_span_row) && $stable(m_span_colour) && $stable(m_pixel_count))

    // Reset empties the output register.
    `TSR_ASSERT_ALWAYS(a_rst_clears, aclk, !aresetn |=> !m_valid)

    // Pixels are only drawn on rows with a non-negative index.
    `TSR_ASSERT(a_row_on_screen, aclk, aresetn, m_valid && (m_pixel_count != 13'd0) |-> !m_span_row[15])

    // A drawn span starts inside the 13 bit width range.
    `TSR_ASSERT(a_start_in_range, aclk, aresetn, m_valid && (m_pixel_count != 13'd0) |-> (m_span_start[14:13] == 2'b00))

endmodule

bind triangle_span_rasterizer tsr_chk u_chk (.*);
